// File: hw/rtl/logrgb_pkg.sv
package logrgb_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int BLUR_RADIUS_DEF = 2;

  // one accumulator cell per Laplacian tap point
  localparam int NCELL  = 5;
  localparam int PROD_W = 40;   // 32-bit weight product times 8-bit sample

  localparam logic [2:0] PT_UP  = 3'd0;
  localparam logic [2:0] PT_DN  = 3'd1;
  localparam logic [2:0] PT_LF  = 3'd2;
  localparam logic [2:0] PT_RT  = 3'd3;
  localparam logic [2:0] PT_CTR = 3'd4;

  // one weighted tap travelling down the cell chain
  typedef struct packed {
    logic                         valid;
    logic [2:0]                   pid;
    logic [2:0][PROD_W-1:0]       prod;
  } tok_t;

  // mirror an index into [0, n-1], border pixel not repeated
  function automatic logic [12:0] reflect101(logic signed [14:0] i, logic [12:0] n);
    logic signed [14:0] ns;
    logic signed [14:0] r;
    ns = $signed({2'b00, n});
    if (i < 0) begin
      r = -i;
    end else if (i >= ns) begin
      r = ns + ns - 15'sd2 - i;
    end else begin
      r = i;
    end
    return r[12:0];
  endfunction

endpackage

// File: hw/rtl/logrgb_ram.sv
module logrgb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/logrgb_cell.sv
module logrgb_cell #(
  parameter int IDX  = 0,
  parameter int ACCW = 45
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clear,
  input  logrgb_pkg::tok_t            tok_in,
  output logrgb_pkg::tok_t            tok_out,
  output logic [2:0][ACCW-1:0]        acc
);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_in;
    end
  end

  // picks off taps addressed to this point, passes everything on
  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (tok_in.valid && tok_in.pid == 3'(IDX)) begin
      for (int ch = 0; ch < 3; ch++) begin
        acc[ch] <= acc[ch] + ACCW'(tok_in.prod[ch]);
      end
    end
  end

endmodule

// File: hw/rtl/laplacian_of_gaussian_rgb_top.sv
// Laplacian of Gaussian over an RGB raster stream.
// s_* channel: one transaction per item. s_tuser=0 carries a pixel in
// s_tdata, s_tuser=1 is a drain tick. After the last pixel of a frame the
// source sends (BLUR_RADIUS+1)*(W+1) drain ticks to flush the frame.
// m_* channel: one transaction per output pixel, raster order, response
// in m_tdata[12:0] (signed), m_tlast on the final pixel of the frame.
// APB port: eight registers at 4*i (geometry, row and column weights).
// Writing width or height restarts the frame.
// Timing: items that produce no output are taken one per cycle while the
// engine is idle. An item that produces an output holds s_tready low
// while the engine works: the (2R+1)^2 taps (25 at R=2) of each of the
// five blurred points are read one per cycle from the single read port
// of the raw line store, run through the weight multipliers and summed
// in a chain of five cells. The result is registered with m_tvalid.
// If the sink stalls, the finished result waits in the output register
// and the next item is still accepted; a second result waits in the
// engine until the register frees up.
// Reset clears the frame counters and handshake state and restores the
// default registers; line store contents are not cleared.
module laplacian_of_gaussian_rgb_top #(
  parameter int MAX_WIDTH   = logrgb_pkg::MAX_WIDTH_DEF,
  parameter int BLUR_RADIUS = logrgb_pkg::BLUR_RADIUS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // blue [7:0], green [15:8], red [23:16]
  input  logic        s_tuser,   // kind: 0 pixel, 1 drain tick
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // response_times3 [12:0], zero [15:13]
  output logic        m_tlast
);

  localparam int TAPS  = 2 * BLUR_RADIUS + 1;
  localparam int RING  = 1 << $clog2(2 * BLUR_RADIUS + 3);
  localparam int RB    = $clog2(RING);
  localparam int CB    = $clog2(MAX_WIDTH);
  localparam int DEPTH = RING * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(TAPS);
  localparam int ACCW  = logrgb_pkg::PROD_W + $clog2(TAPS * TAPS);
  localparam int NCELL = logrgb_pkg::NCELL;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ROW_W0 = 3'd2;
  localparam logic [2:0] REG_ROW_W1 = 3'd3;
  localparam logic [2:0] REG_ROW_W2 = 3'd4;
  localparam logic [2:0] REG_COL_W0 = 3'd5;
  localparam logic [2:0] REG_COL_W1 = 3'd6;
  localparam logic [2:0] REG_COL_W2 = 3'd7;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // ---------------- configuration ----------------
  logic [10:0] image_width;
  logic [12:0] image_height;
  logic [15:0] rw [3];
  logic [15:0] cw [3];
  logic        cfg_wr;
  logic        geom_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign geom_wr = cfg_wr & ((paddr[4:2] == REG_WIDTH) | (paddr[4:2] == REG_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd512;
      image_height <= 13'd512;
      rw[0] <= 16'd16474; rw[1] <= 16'd14537; rw[2] <= 16'd9993;
      cw[0] <= 16'd16474; cw[1] <= 16'd14537; cw[2] <= 16'd9993;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_WIDTH:  image_width  <= pwdata[10:0];
        REG_HEIGHT: image_height <= pwdata[12:0];
        REG_ROW_W0: rw[0] <= pwdata[15:0];
        REG_ROW_W1: rw[1] <= pwdata[15:0];
        REG_ROW_W2: rw[2] <= pwdata[15:0];
        REG_COL_W0: cw[0] <= pwdata[15:0];
        REG_COL_W1: cw[1] <= pwdata[15:0];
        REG_COL_W2: cw[2] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_WIDTH:  prdata = {21'd0, image_width};
      REG_HEIGHT: prdata = {19'd0, image_height};
      REG_ROW_W0: prdata = {16'd0, rw[0]};
      REG_ROW_W1: prdata = {16'd0, rw[1]};
      REG_ROW_W2: prdata = {16'd0, rw[2]};
      REG_COL_W0: prdata = {16'd0, cw[0]};
      REG_COL_W1: prdata = {16'd0, cw[1]};
      REG_COL_W2: prdata = {16'd0, cw[2]};
      default:    prdata = 32'd0;
    endcase
  end

  // effective geometry, clamped
  logic [12:0] eff_w;
  logic [12:0] eff_h;
  logic [14:0] lag;

  always_comb begin
    eff_w = {2'b00, image_width};
    if (eff_w < 13'd3) eff_w = 13'd3;
    if (eff_w > 13'(MAX_WIDTH)) eff_w = 13'(MAX_WIDTH);
    eff_h = image_height;
    if (eff_h < 13'd3) eff_h = 13'd3;
    if (eff_h > 13'd4096) eff_h = 13'd4096;
  end

  assign lag = 15'(BLUR_RADIUS + 1) * (15'(eff_w) + 15'd1);

  // ---------------- frame bookkeeping ----------------
  logic [1:0]  state;
  logic [12:0] in_row;
  logic [12:0] in_col;
  logic [12:0] out_row;
  logic [12:0] out_col;
  logic [14:0] lag_cnt;
  logic [12:0] r_lat;
  logic [12:0] c_lat;
  logic        last_lat;

  logic acc_in;
  logic pix_exp;
  logic ignored;
  logic store;
  logic out_due;
  logic out_last;

  assign s_tready = (state == ST_IDLE);
  assign acc_in   = s_tvalid & s_tready;
  assign pix_exp  = in_row < eff_h;
  assign ignored  = pix_exp & s_tuser;
  assign store    = pix_exp & ~s_tuser;
  assign out_due  = ~ignored & (lag_cnt >= lag);
  assign out_last = (out_row == eff_h - 13'd1) && (out_col == eff_w - 13'd1);

  always_ff @(posedge clk) begin
    if (rst || geom_wr) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
      lag_cnt <= '0;
    end else if (acc_in) begin
      if (store) begin
        if (in_col == eff_w - 13'd1) begin
          in_col <= '0;
          in_row <= in_row + 13'd1;
        end else begin
          in_col <= in_col + 13'd1;
        end
      end
      if (!ignored) begin
        if (!out_due) begin
          lag_cnt <= lag_cnt + 15'd1;
        end else if (out_last) begin
          in_row  <= '0;
          in_col  <= '0;
          out_row <= '0;
          out_col <= '0;
          lag_cnt <= '0;
        end else if (out_col == eff_w - 13'd1) begin
          out_col <= '0;
          out_row <= out_row + 13'd1;
        end else begin
          out_col <= out_col + 13'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in && out_due) begin
      r_lat    <= out_row;
      c_lat    <= out_col;
      last_lat <= out_last;
    end
  end

  // ---------------- tap sequencer ----------------
  logic [2:0]    p_cnt;
  logic [TW-1:0] a_cnt;
  logic [TW-1:0] b_cnt;
  logic [2:0]    fl_cnt;
  logic          out_free;
  logic          clear;

  assign clear    = acc_in & out_due;
  assign out_free = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (clear) state <= ST_RUN;
        end
        ST_RUN: begin
          if (b_cnt == TW'(TAPS - 1) && a_cnt == TW'(TAPS - 1) &&
              p_cnt == 3'(NCELL - 1)) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (fl_cnt == 3'(NCELL)) state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      p_cnt  <= '0;
      a_cnt  <= '0;
      b_cnt  <= '0;
      fl_cnt <= '0;
    end else if (state == ST_RUN) begin
      if (b_cnt == TW'(TAPS - 1)) begin
        b_cnt <= '0;
        if (a_cnt == TW'(TAPS - 1)) begin
          a_cnt <= '0;
          p_cnt <= p_cnt + 3'd1;
        end else begin
          a_cnt <= a_cnt + TW'(1);
        end
      end else begin
        b_cnt <= b_cnt + TW'(1);
      end
    end else if (state == ST_FLUSH) begin
      fl_cnt <= fl_cnt + 3'd1;
    end
  end

  // source address of the current tap
  logic signed [14:0] pr_i;
  logic signed [14:0] pc_i;
  logic [12:0]        pt_row;
  logic [12:0]        pt_col;
  logic [12:0]        src_row;
  logic [12:0]        src_col;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [TW-1:0]      wa;
  logic [TW-1:0]      wb;

  always_comb begin
    pr_i = $signed({2'b00, r_lat});
    pc_i = $signed({2'b00, c_lat});
    case (p_cnt)
      logrgb_pkg::PT_UP: pr_i = pr_i - 15'sd1;
      logrgb_pkg::PT_DN: pr_i = pr_i + 15'sd1;
      logrgb_pkg::PT_LF: pc_i = pc_i - 15'sd1;
      logrgb_pkg::PT_RT: pc_i = pc_i + 15'sd1;
      default: ;
    endcase
    pt_row  = logrgb_pkg::reflect101(pr_i, eff_h);
    pt_col  = logrgb_pkg::reflect101(pc_i, eff_w);
    src_row = logrgb_pkg::reflect101($signed({2'b00, pt_row}) + $signed(15'(a_cnt))
                                     - 15'sd2 * 15'(BLUR_RADIUS) / 15'sd2, eff_h);
    src_col = logrgb_pkg::reflect101($signed({2'b00, pt_col}) + $signed(15'(b_cnt))
                                     - 15'(BLUR_RADIUS), eff_w);
    rd_addr = AW'(src_row[RB-1:0]) * AW'(MAX_WIDTH) + AW'(src_col[CB-1:0]);
    wr_addr = AW'(in_row[RB-1:0]) * AW'(MAX_WIDTH) + AW'(in_col[CB-1:0]);
    wa = (a_cnt < TW'(BLUR_RADIUS)) ? TW'(BLUR_RADIUS) - a_cnt : a_cnt - TW'(BLUR_RADIUS);
    wb = (b_cnt < TW'(BLUR_RADIUS)) ? TW'(BLUR_RADIUS) - b_cnt : b_cnt - TW'(BLUR_RADIUS);
  end

  logic [23:0] rd_data;

  logrgb_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_raw_lines (
    .clk   (clk),
    .we    (acc_in & store),
    .waddr (wr_addr),
    .wdata (s_tdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // ---------------- weight pipeline ----------------
  logic        s1_valid;
  logic [2:0]  s1_pid;
  logic [31:0] s1_wprod;
  logrgb_pkg::tok_t s2_tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_tok.valid <= 1'b0;
    end else begin
      s1_valid     <= (state == ST_RUN);
      s2_tok.valid <= s1_valid;
    end
    s1_pid   <= p_cnt;
    s1_wprod <= 32'(rw[wa[1:0]]) * 32'(cw[wb[1:0]]);
    s2_tok.pid <= s1_pid;
    for (int ch = 0; ch < 3; ch++) begin
      s2_tok.prod[ch] <= 40'(s1_wprod) * 40'(rd_data[8*ch +: 8]);
    end
  end

  // ---------------- accumulator chain ----------------
  logrgb_pkg::tok_t           chain [NCELL+1];
  logic [2:0][ACCW-1:0]       cell_acc [NCELL];

  assign chain[0] = s2_tok;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    logrgb_cell #(
      .IDX  (g),
      .ACCW (ACCW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (clear),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1]),
      .acc     (cell_acc[g])
    );
  end

  // ---------------- Laplacian and output ----------------
  function automatic logic [7:0] blur8(logic [ACCW-1:0] a);
    return (a[ACCW-1:40] != '0) ? 8'd255 : a[39:32];
  endfunction

  logic signed [12:0] resp;

  always_comb begin
    resp = '0;
    for (int ch = 0; ch < 3; ch++) begin
      resp = resp
           + $signed({5'd0, blur8(cell_acc[logrgb_pkg::PT_UP][ch])})
           + $signed({5'd0, blur8(cell_acc[logrgb_pkg::PT_DN][ch])})
           + $signed({5'd0, blur8(cell_acc[logrgb_pkg::PT_LF][ch])})
           + $signed({5'd0, blur8(cell_acc[logrgb_pkg::PT_RT][ch])})
           - $signed({3'd0, blur8(cell_acc[logrgb_pkg::PT_CTR][ch]), 2'b00});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {3'd0, resp};
      m_tlast <= last_lat;
    end
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // register map, byte address is 4 * index
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ROW_W0 = 3'd2;
  localparam logic [2:0] REG_COL_W0 = 3'd5;

  // item kinds carried on s_tuser
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam int RING    = 8;     // rows kept by the predictor's line ring
  localparam int MAXW    = 1024;
  localparam int MAXH    = 4096;
  localparam int SETTLE  = 160;   // > one full result computation
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic        kind;
    logic [23:0] pix;   // blue [7:0], green [15:8], red [23:16]
  } pixel_item_t;

  typedef struct packed {
    logic [12:0] resp;
    logic        last;
  } log_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // blue [7:0], green [15:8], red [23:16]
  logic        s_tuser = 1'b0; // kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // response_times3 [12:0], zero [15:13]
  logic        m_tlast;

  laplacian_of_gaussian_rgb_top uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  pixel_item_t pending_pixels[$];
  log_result_t expected_log[$];
  bit          calm = 1'b0;      // no idling on either side while set
  int          errors = 0;
  int          results_seen = 0;
  int          stuck_cycles = 0;

  // ---------------- LoG predictor state ----------------
  logic [23:0] line_ring[RING][MAXW];
  logic [10:0] width_reg;
  logic [12:0] height_reg;
  logic [15:0] row_wt[3];
  logic [15:0] col_wt[3];
  int unsigned in_row, in_col, out_idx, lag_seen;

  function automatic int mirror(int i, int n);
    if (i < 0) return -i;
    if (i >= n) return 2 * n - 2 - i;
    return i;
  endfunction

  function automatic int cur_w();
    int w;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MAXW) w = MAXW;
    return w;
  endfunction

  function automatic int cur_h();
    int h;
    h = height_reg;
    if (h < 3) h = 3;
    if (h > MAXH) h = MAXH;
    return h;
  endfunction

  // Gaussian of one channel at (r, c), floor of Q0.32 sum, saturated at 255
  function automatic int gauss_chan(int r, int c, int ch, int w, int h);
    longint unsigned acc;
    int rr, cc;
    acc = 0;
    for (int a = -2; a <= 2; a++) begin
      rr = mirror(r + a, h) % RING;
      for (int b = -2; b <= 2; b++) begin
        cc = mirror(c + b, w);
        acc += longint'(row_wt[a < 0 ? -a : a]) * longint'(col_wt[b < 0 ? -b : b])
               * longint'(line_ring[rr][cc][8*ch +: 8]);
      end
    end
    acc = acc >> 32;
    return (acc > 255) ? 255 : int'(acc);
  endfunction

  function automatic int laplace_sum(int r, int c, int w, int h);
    int s, up, dn, lf, rt;
    s = 0;
    up = mirror(r - 1, h);
    dn = mirror(r + 1, h);
    lf = mirror(c - 1, w);
    rt = mirror(c + 1, w);
    for (int ch = 0; ch < 3; ch++)
      s += gauss_chan(up, c, ch, w, h) + gauss_chan(dn, c, ch, w, h)
         + gauss_chan(r, lf, ch, w, h) + gauss_chan(r, rt, ch, w, h)
         - 4 * gauss_chan(r, c, ch, w, h);
    return s;
  endfunction

  function automatic void restart_frame();
    in_row = 0;
    in_col = 0;
    out_idx = 0;
    lag_seen = 0;
  endfunction

  function automatic void predict_log(pixel_item_t it);
    int w, h, resp;
    bit last;
    log_result_t res;
    w = cur_w();
    h = cur_h();
    if (in_row < h) begin
      if (it.kind == KIND_DRAIN) return;   // drain while pixels still owed
      line_ring[in_row % RING][in_col] = it.pix;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end
    if (lag_seen < 3 * (w + 1)) begin
      lag_seen++;
      return;
    end
    resp = laplace_sum(out_idx / w, out_idx % w, w, h);
    last = (out_idx == w * h - 1);
    if (last) restart_frame();
    else out_idx++;
    res.resp = resp[12:0];
    res.last = last;
    expected_log.push_back(res);
  endfunction

  // ---------------- stream driver ----------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_pixels.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
        pixel_item_t it;
        it = pending_pixels.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= it.pix;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 34);
  end

  // ---------------- monitor / checker ----------------
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        predict_log('{kind: s_tuser, pix: s_tdata});
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_log.size() == 0) begin
          $display("%0t: unexpected result transaction: tdata=%h tlast=%b",
                   $time, m_tdata, m_tlast);
          errors++;
        end else begin
          log_result_t e;
          e = expected_log.pop_front();
          if (m_tdata !== {3'b000, e.resp}) begin
            $display("%0t: response mismatch: expected %0d (%h) actual %h",
                     $time, $signed(e.resp), {3'b000, e.resp}, m_tdata);
            errors++;
          end
          if (m_tlast !== e.last) begin
            $display("%0t: tlast mismatch: expected %b actual %b",
                     $time, e.last, m_tlast);
            errors++;
          end
        end
      end
      // watchdog: no transaction on either side while work is outstanding
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (pending_pixels.size() == 0 && expected_log.size() == 0 && !s_tvalid))
        stuck_cycles <= 0;
      else
        stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired, %0d results still owed", $time,
                 expected_log.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------- APB register write ----------------
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);                 // register written at this edge
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WIDTH:  begin width_reg = val[10:0]; restart_frame(); end
      REG_HEIGHT: begin height_reg = val[12:0]; restart_frame(); end
      default: begin
        if (idx < REG_COL_W0) row_wt[idx - REG_ROW_W0] = val[15:0];
        else col_wt[idx - REG_COL_W0] = val[15:0];
      end
    endcase
  endtask

  task automatic set_weights(logic [15:0] r0, r1, r2, c0, c1, c2);
    reg_write(REG_ROW_W0, r0);
    reg_write(REG_ROW_W0 + 3'd1, r1);
    reg_write(REG_ROW_W0 + 3'd2, r2);
    reg_write(REG_COL_W0, c0);
    reg_write(REG_COL_W0 + 3'd1, c1);
    reg_write(REG_COL_W0 + 3'd2, c2);
  endtask

  // wait for all results, then let the engine settle before touching registers
  task automatic drain_wait();
    while (pending_pixels.size() > 0 || s_tvalid || expected_log.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [23:0] make_pixel(int style, int idx);
    case (style)
      0: return 24'($urandom());
      1: return {$urandom_range(1) ? 8'hff : 8'h00, $urandom_range(1) ? 8'hff : 8'h00,
                 $urandom_range(1) ? 8'hff : 8'h00};
      2: return (idx % 2) ? 24'hffffff : 24'h000000;
      default: return {8'($urandom_range(3)), 8'($urandom_range(252, 255)),
                       8'($urandom_range(255))};
    endcase
  endfunction

  // one full frame: pixels (with stray drain ticks), then the flush run
  task automatic queue_frame(int w, int h, int style, ref int counted);
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(19) == 0)
        pending_pixels.push_back('{kind: KIND_DRAIN, pix: 24'($urandom())});
      pending_pixels.push_back('{kind: KIND_PIXEL, pix: make_pixel(style, i)});
      counted++;
    end
    // after the frame is complete a pixel behaves as a drain tick
    for (int i = 0; i < 3 * (w + 1); i++) begin
      pending_pixels.push_back('{kind: $urandom_range(3) == 0 ? KIND_PIXEL : KIND_DRAIN,
                                 pix: 24'($urandom())});
      counted++;
    end
    // stray drain ticks at the start of the next frame are ignored
    if ($urandom_range(1))
      pending_pixels.push_back('{kind: KIND_DRAIN, pix: 24'($urandom())});
  endtask

  initial begin
    int counted;
    int frames;
    int w, h;
    counted = 0;
    frames = 0;
    width_reg = 11'd512;
    height_reg = 13'd512;
    row_wt = '{16474, 14537, 9993};
    col_wt = '{16474, 14537, 9993};
    restart_frame();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: smallest frame under default weights, dark/bright extremes
    reg_write(REG_WIDTH, 3);
    reg_write(REG_HEIGHT, 3);
    calm = 1'b1;
    queue_frame(3, 3, 2, counted);
    drain_wait();
    calm = 1'b0;

    // out-of-range geometry clamps to 3x3; full-scale weights saturate
    reg_write(REG_WIDTH, 0);
    reg_write(REG_HEIGHT, 1);
    set_weights(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    queue_frame(3, 3, 1, counted);
    drain_wait();

    // zero weights: every blurred value is zero
    set_weights(0, 0, 0, 0, 0, 0);
    reg_write(REG_WIDTH, 4);
    queue_frame(4, 3, 0, counted);
    drain_wait();

    // largest geometry written, then replaced before any pixel is sent
    reg_write(REG_WIDTH, 32'hffff_ffff);
    reg_write(REG_HEIGHT, 32'hffff_ffff);
    reg_write(REG_WIDTH, 5);
    reg_write(REG_HEIGHT, 4);
    set_weights(16474, 14537, 9993, 16474, 14537, 9993);
    queue_frame(5, 4, 3, counted);
    drain_wait();

    // random phases: small frames, varied weights
    while (counted < 1400) begin
      w = $urandom_range(3, 9);
      h = $urandom_range(3, 6);
      reg_write(REG_WIDTH, w);
      reg_write(REG_HEIGHT, h);
      case ($urandom_range(3))
        0: set_weights(16474, 14537, 9993, 16474, 14537, 9993);
        1: set_weights(16'($urandom()), 16'($urandom()), 16'($urandom()),
                       16'($urandom()), 16'($urandom()), 16'($urandom()));
        default: set_weights(16'($urandom_range(40000)), 16'($urandom_range(30000)),
                             16'($urandom_range(20000)), 16'($urandom_range(40000)),
                             16'($urandom_range(30000)), 16'($urandom_range(20000)));
      endcase
      calm = ($urandom_range(7) == 0);
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        queue_frame(w, h, $urandom_range(3), counted);
        frames++;
      end
      drain_wait();
      calm = 1'b0;
    end

    $display("Covered %0d stream items over %0d random frames plus directed frames,",
             counted, frames);
    $display("%0d result transactions checked, %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: laplacian_of_gaussian_rgb_top.f
hw/rtl/logrgb_pkg.sv
hw/rtl/logrgb_ram.sv
hw/rtl/logrgb_cell.sv
hw/rtl/laplacian_of_gaussian_rgb_top.sv
test/tb_top.sv
